// ----- src/drb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the DRAM row-buffer timing block: field widths, codes and reset values.
// Used by the top level and the testbench; depends on nothing.
package drb_pkg;

    localparam int ROW_BYTES = 1024;
    localparam int NUM_ROWS  = 1024;
    localparam int COL_W     = $clog2(ROW_BYTES);
    localparam int ROW_W     = $clog2(NUM_ROWS);
    localparam int ADDR_W    = 20;
    localparam int REG_W     = 5;
    localparam int DLY_W     = 8;
    localparam int RCNT_W    = DLY_W + 1;
    localparam int LOADS_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    localparam logic [DLY_W-1:0] ROW_DELAY_RST = 8'd10;
    localparam logic [DLY_W-1:0] COL_DELAY_RST = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_DELAY = 1'b0,
        CFG_COL_DELAY = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACCESS = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_CONFLICT = 2'd2,
        KIND_HIT      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ACTIVATE = 2'd1,
        PH_WRBACK   = 2'd2,
        PH_COLUMN   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    // Result fields known at accept time; the row count joins in stage 1, from the count RAM.
    typedef struct packed {
        logic             accepted;
        t_kind            kind;
        t_phase           phase;
        logic [ROW_W-1:0] phase_row;
        logic [COL_W-1:0] phase_col;
        logic             done;
        logic             busy_valid;
        logic [REG_W-1:0] busy_reg;
    } t_res;

endpackage

// ----- src/drb_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during write to the same address returns the old contents; no dependencies.
module drb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/dram_row_buffer_timing_top.sv -----
`timescale 1ns / 1ps
// Top level of the DRAM row-buffer timing block: bank timing state and activation counts.
// Depends on drb_pkg and drb_ram.
//
// Each input word is one DRAM clock cycle; the block takes one word per clock while
// s_axis_tready is high and returns one result word for it through stage 1 and an output
// register. Timing state sits in flip-flops and is updated at accept; per-row activation
// counts live in one RAM that is read at accept and written back from stage 1 as it
// advances, with the written value forwarded when the next word reads the same row.
// After reset the block clears all NUM_ROWS (1024) rows of the count RAM with s_axis_tready
// low; configuration writes are taken throughout. s_axis_tready follows the output handshake,
// so the rate is one word per cycle whenever the result side keeps taking words.
module dram_row_buffer_timing_top #(
    parameter int COUNT_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [drb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [drb_pkg::DLY_W-1:0]           i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // address[19:0], is_load[20], dest_reg[25:21], query_row[35:26], zero[39:36]
    input  logic [drb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // accepted[0], phase[2:1], phase_row[12:3], phase_col[22:13], access_done[23],
    // busy_valid[24], busy_reg[29:25], row_loads[61:30], zero[63:62]
    output logic [drb_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // access_kind[1:0]
    output logic [1:0]                          m_axis_tuser
);
    import drb_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [DLY_W-1:0] r_row_delay;
    logic [DLY_W-1:0] r_col_delay;

    // bank timing state
    logic              r_open_valid, n_open_valid;
    logic [ROW_W-1:0]  r_open_row, n_open_row;
    logic [COL_W-1:0]  r_open_col, n_open_col;
    logic [ROW_W-1:0]  r_evict_row, n_evict_row;
    logic [RCNT_W-1:0] r_row_left, n_row_left;
    logic [DLY_W-1:0]  r_col_left, n_col_left;
    logic              r_pend_valid, n_pend_valid;
    logic [REG_W-1:0]  r_pend_reg, n_pend_reg;

    // clearing sweep
    t_state            r_state;
    logic [ROW_W-1:0]  r_clr_addr;

    // input fields
    t_mode             in_mode;
    logic [ADDR_W-1:0] in_addr;
    logic              in_is_load;
    logic [REG_W-1:0]  in_dest;
    logic [ROW_W-1:0]  in_query;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;

    logic              in_accept;
    t_res              n_res;
    logic              n_inc;
    logic [ROW_W-1:0]  rd_addr;

    // stage 1: count RAM data arrives
    logic              r_s1_valid;
    t_res              r_s1_res;
    logic              r_s1_inc;
    logic              r_s1_qry;
    logic [ROW_W-1:0]  r_s1_row;
    logic              r_fwd;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic              s1_adv;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] s1_cnt;
    logic [COUNT_BITS-1:0] s1_cnt_inc;
    logic [LOADS_W-1:0]    s1_cnt_sat;
    logic [LOADS_W-1:0]    s1_loads;

    // RAM write side
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic              upd_en;

    // stage 2: output register
    logic              r_s2_valid;
    t_res              r_s2_res;
    logic [LOADS_W-1:0] r_s2_loads;

    assign in_addr    = s_axis_tdata[ADDR_W-1:0];
    assign in_is_load = s_axis_tdata[ADDR_W];
    assign in_dest    = s_axis_tdata[ADDR_W+REG_W:ADDR_W+1];
    assign in_query   = s_axis_tdata[ADDR_W+REG_W+ROW_W:ADDR_W+REG_W+1];
    assign in_mode    = t_mode'(s_axis_tuser);
    assign in_col     = in_addr[COL_W-1:0];
    assign in_row     = in_addr[COL_W+ROW_W-1:COL_W];

    assign s1_adv        = !r_s2_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_RUN) && (!r_s1_valid || s1_adv);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_delay <= ROW_DELAY_RST;
            r_col_delay <= COL_DELAY_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_DELAY: r_row_delay <= i_cfg_data;
                CFG_COL_DELAY: r_col_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase report, countdown and request handling for the current input word
    always_comb begin
        n_res        = '0;
        n_open_valid = r_open_valid;
        n_open_row   = r_open_row;
        n_open_col   = r_open_col;
        n_evict_row  = r_evict_row;
        n_row_left   = r_row_left;
        n_col_left   = r_col_left;
        n_pend_valid = r_pend_valid;
        n_pend_reg   = r_pend_reg;
        n_inc        = 1'b0;
        rd_addr      = in_query;

        if (r_row_left != '0 || r_col_left != '0) begin
            if (r_row_left != '0 && r_row_left <= {1'b0, r_row_delay}) begin
                n_res.phase     = PH_ACTIVATE;
                n_res.phase_row = r_open_row;
            end else if (r_row_left > {1'b0, r_row_delay}
                         && r_row_left <= {r_row_delay, 1'b0}) begin
                n_res.phase     = PH_WRBACK;
                n_res.phase_row = r_evict_row;
            end else begin
                n_res.phase     = PH_COLUMN;
                n_res.phase_col = r_open_col;
            end
        end
        n_res.done = (r_row_left == '0) && (r_col_left == DLY_W'(1));

        if (r_col_left == '0) begin
            n_pend_valid = 1'b0;
            n_pend_reg   = '0;
            n_row_left   = '0;
        end else if (r_row_left != '0) begin
            n_row_left = r_row_left - RCNT_W'(1);
        end else begin
            n_col_left = r_col_left - DLY_W'(1);
        end

        if (in_mode == MODE_ACCESS && n_row_left == '0 && n_col_left == '0) begin
            n_res.accepted = 1'b1;
            if (r_open_valid && in_row == r_open_row) begin
                n_res.kind = KIND_HIT;
                n_row_left = '0;
            end else begin
                if (r_open_valid) begin
                    n_res.kind  = KIND_CONFLICT;
                    n_evict_row = r_open_row;
                    n_row_left  = {r_row_delay, 1'b0};
                end else begin
                    n_res.kind = KIND_EMPTY;
                    n_row_left = {1'b0, r_row_delay};
                end
                n_inc        = 1'b1;
                rd_addr      = in_row;
                n_open_row   = in_row;
                n_open_valid = 1'b1;
            end
            n_open_col   = in_col;
            n_col_left   = r_col_delay;
            n_pend_valid = in_is_load;
            n_pend_reg   = in_is_load ? in_dest : '0;
        end

        n_res.busy_valid = n_pend_valid;
        n_res.busy_reg   = n_pend_valid ? n_pend_reg : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_valid <= 1'b0;
            r_open_row   <= '0;
            r_open_col   <= '0;
            r_evict_row  <= '0;
            r_row_left   <= '0;
            r_col_left   <= '0;
            r_pend_valid <= 1'b0;
            r_pend_reg   <= '0;
        end else if (in_accept) begin
            r_open_valid <= n_open_valid;
            r_open_row   <= n_open_row;
            r_open_col   <= n_open_col;
            r_evict_row  <= n_evict_row;
            r_row_left   <= n_row_left;
            r_col_left   <= n_col_left;
            r_pend_valid <= n_pend_valid;
            r_pend_reg   <= n_pend_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ROW_W'(1);
                    if (r_clr_addr == ROW_W'(NUM_ROWS - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN:  r_state <= ST_RUN;
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    // stage 1: count read-modify-write
    assign s1_cnt     = r_fwd ? r_fwd_data : ram_rdata;
    assign s1_cnt_inc = (s1_cnt == CNT_MAX) ? s1_cnt : s1_cnt + COUNT_BITS'(1);

    generate
        if (COUNT_BITS > LOADS_W) begin : g_sat
            assign s1_cnt_sat = (|s1_cnt[COUNT_BITS-1:LOADS_W]) ? {LOADS_W{1'b1}}
                                                                : s1_cnt[LOADS_W-1:0];
        end else begin : g_ext
            assign s1_cnt_sat = LOADS_W'(s1_cnt);
        end
    endgenerate

    assign s1_loads = r_s1_qry ? s1_cnt_sat : '0;

    assign upd_en  = r_s1_valid && s1_adv && r_s1_inc;
    assign wr_en   = (r_state == ST_CLEAR) || upd_en;
    assign wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_s1_row;
    assign wr_data = (r_state == ST_CLEAR) ? '0 : s1_cnt_inc;

    drb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_ROWS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_res   <= n_res;
            r_s1_inc   <= n_inc;
            r_s1_qry   <= (in_mode == MODE_QUERY);
            r_s1_row   <= rd_addr;
            r_fwd      <= upd_en && (r_s1_row == rd_addr);
            r_fwd_data <= s1_cnt_inc;
        end
    end

    // stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_s2_res   <= r_s1_res;
            r_s2_loads <= s1_loads;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tuser  = r_s2_res.kind;
    assign m_axis_tdata  = {2'b00, r_s2_loads, r_s2_res.busy_reg, r_s2_res.busy_valid,
                            r_s2_res.done, r_s2_res.phase_col, r_s2_res.phase_row,
                            r_s2_res.phase, r_s2_res.accepted};

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for dram_row_buffer_timing_top: random and directed DRAM input words, self-checking
// against an in-bench bank timing predictor. Depends on drb_pkg and the block's RTL.
module tb_top;
    import drb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_mode              mode;
        logic [ADDR_W-1:0]  addr;
        logic               is_load;
        logic [REG_W-1:0]   dest;
        logic [ROW_W-1:0]   qrow;
    } t_dram_cycle;

    typedef struct {
        logic               accepted;
        t_kind              kind;
        t_phase             phase;
        logic [ROW_W-1:0]   phase_row;
        logic [COL_W-1:0]   phase_col;
        logic               done;
        logic               busy_valid;
        logic [REG_W-1:0]   busy_reg;
        logic [LOADS_W-1:0] row_loads;
    } t_bank_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [DLY_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    dram_row_buffer_timing_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [DLY_W-1:0]   row_dly = ROW_DELAY_RST;
    logic [DLY_W-1:0]   col_dly = COL_DELAY_RST;
    logic               open_valid = 1'b0;
    logic [ROW_W-1:0]   open_row = '0;
    logic [COL_W-1:0]   open_col = '0;
    logic [ROW_W-1:0]   evict_row = '0;
    logic [RCNT_W-1:0]  row_left = '0;
    logic [DLY_W-1:0]   col_left = '0;
    logic               pend_valid = 1'b0;
    logic [REG_W-1:0]   pend_reg = '0;
    logic [LOADS_W-1:0] act_count [NUM_ROWS];

    t_dram_cycle  pending_cycles[$];
    t_bank_report bank_reports[$];
    t_dram_cycle  cur_cycle;
    logic [ROW_W-1:0] hot_rows [4];

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void step_bank(input t_dram_cycle c);
        t_bank_report r;
        int unsigned rd;
        logic [ROW_W-1:0] row;
        r.accepted = 1'b0;
        r.kind = KIND_NONE;
        r.phase = PH_IDLE;
        r.phase_row = '0;
        r.phase_col = '0;
        r.row_loads = '0;
        rd = row_dly;
        if (row_left != 0 || col_left != 0) begin
            if (row_left != 0 && row_left <= rd) begin
                r.phase = PH_ACTIVATE;
                r.phase_row = open_row;
            end else if (row_left > rd && row_left <= 2 * rd) begin
                r.phase = PH_WRBACK;
                r.phase_row = evict_row;
            end else begin
                r.phase = PH_COLUMN;
                r.phase_col = open_col;
            end
        end
        r.done = (row_left == 0 && col_left == 1);
        if (col_left == 0) begin
            pend_valid = 1'b0;
            pend_reg = '0;
            row_left = '0;
        end else if (row_left != 0) begin
            row_left = row_left - 1'b1;
        end else begin
            col_left = col_left - 1'b1;
        end
        if (c.mode == MODE_ACCESS && row_left == 0 && col_left == 0) begin
            row = ROW_W'((c.addr / ROW_BYTES) % NUM_ROWS);
            r.accepted = 1'b1;
            if (open_valid && row == open_row) begin
                r.kind = KIND_HIT;
            end else begin
                if (open_valid) begin
                    r.kind = KIND_CONFLICT;
                    evict_row = open_row;
                    row_left = RCNT_W'(2 * rd);
                end else begin
                    r.kind = KIND_EMPTY;
                    row_left = RCNT_W'(rd);
                end
                if (act_count[row] != '1)
                    act_count[row] = act_count[row] + 1'b1;
                open_row = row;
                open_valid = 1'b1;
            end
            open_col = COL_W'(c.addr % ROW_BYTES);
            col_left = col_dly;
            pend_valid = c.is_load;
            pend_reg = c.is_load ? c.dest : '0;
        end
        if (c.mode == MODE_QUERY && c.qrow < NUM_ROWS)
            r.row_loads = act_count[c.qrow];
        r.busy_valid = pend_valid;
        r.busy_reg = pend_valid ? pend_reg : '0;
        bank_reports.insert(bank_reports.size(), r);
    endfunction

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("mismatch %s: expected %0h, got %0h", field, want, got);
        end
    endfunction

    function automatic t_dram_cycle rand_cycle();
        t_dram_cycle c;
        int unsigned pick;
        logic [ROW_W-1:0] row;
        pick = $urandom_range(99);
        if (pick < 60)
            c.mode = MODE_ACCESS;
        else if (pick < 78)
            c.mode = MODE_IDLE;
        else if (pick < 92)
            c.mode = MODE_QUERY;
        else
            c.mode = MODE_SPARE;
        if ($urandom_range(9) < 7)
            row = hot_rows[$urandom_range(3)];
        else
            row = ROW_W'($urandom_range(NUM_ROWS - 1));
        c.addr = {row, COL_W'($urandom_range(ROW_BYTES - 1))};
        c.is_load = 1'($urandom_range(1));
        c.dest = REG_W'($urandom_range(31));
        if ($urandom_range(1) == 0)
            c.qrow = hot_rows[$urandom_range(3)];
        else
            c.qrow = ROW_W'($urandom_range(NUM_ROWS - 1));
        return c;
    endfunction

    function automatic void push_cycle(input t_mode mode, input logic [ADDR_W-1:0] addr,
                                       input logic ld, input logic [REG_W-1:0] dest,
                                       input logic [ROW_W-1:0] qrow);
        t_dram_cycle c;
        c.mode = mode;
        c.addr = addr;
        c.is_load = ld;
        c.dest = dest;
        c.qrow = qrow;
        pending_cycles.insert(pending_cycles.size(), c);
    endfunction

    task automatic wait_drained();
        while (pending_cycles.size() != 0 || s_axis_tvalid || bank_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_delays(input logic [DLY_W-1:0] rdly, input logic [DLY_W-1:0] cdly);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ROW_DELAY;
        i_cfg_data <= rdly;
        @(posedge i_clk);
        i_cfg_idx <= CFG_COL_DELAY;
        i_cfg_data <= cdly;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        row_dly = rdly;
        col_dly = cdly;
    endtask

    // driver: predict on accept, hold the word while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                step_bank(cur_cycle);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cycles.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    cur_cycle = pending_cycles.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'b0, cur_cycle.qrow, cur_cycle.dest, cur_cycle.is_load,
                                     cur_cycle.addr};
                    s_axis_tuser <= cur_cycle.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_bank_report r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (bank_reports.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result word %h", m_axis_tdata);
                end else begin
                    r = bank_reports.pop_front();
                    note_mismatch("accepted", r.accepted, m_axis_tdata[0]);
                    note_mismatch("access_kind", r.kind, m_axis_tuser);
                    note_mismatch("phase", r.phase, m_axis_tdata[2:1]);
                    note_mismatch("phase_row", r.phase_row, m_axis_tdata[12:3]);
                    note_mismatch("phase_col", r.phase_col, m_axis_tdata[22:13]);
                    note_mismatch("access_done", r.done, m_axis_tdata[23]);
                    note_mismatch("busy_valid", r.busy_valid, m_axis_tdata[24]);
                    note_mismatch("busy_reg", r.busy_reg, m_axis_tdata[29:25]);
                    note_mismatch("row_loads", r.row_loads, m_axis_tdata[61:30]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [DLY_W-1:0] rdly [7];
        logic [DLY_W-1:0] cdly [7];
        int n_items [7];
        rdly = '{8'd1, 8'd1, 8'd255, 8'd37, 8'd2, 8'd255, 8'd1};
        cdly = '{8'd255, 8'd1, 8'd255, 8'd5, 8'd1, 8'd1, 8'd3};
        n_items = '{200, 350, 150, 250, 350, 150, 300};
        for (int i = 0; i < NUM_ROWS; i++)
            act_count[i] = '0;
        src_gap_pct = 29;
        sink_stall_pct = 74;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle, spare mode with all ones, empty open, busy retries, conflict, two queries
        push_cycle(MODE_IDLE, '0, 1'b0, '0, '0);
        push_cycle(MODE_SPARE, '1, 1'b1, '1, '1);
        push_cycle(MODE_ACCESS, '0, 1'b1, 5'd31, '0);
        for (int i = 0; i < 12; i++)
            push_cycle(MODE_ACCESS, '1, 1'b0, '0, '0);
        push_cycle(MODE_QUERY, '0, 1'b0, '0, '1);
        push_cycle(MODE_QUERY, '0, 1'b1, '0, '0);
        wait_drained();

        // random phases: delays change between them, possibly under a conflict still in flight
        for (int p = 0; p < 7; p++) begin
            if (p == 2) begin
                src_gap_pct = 74;
                sink_stall_pct = 29;
            end else if (p == 4) begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end
            set_delays(rdly[p], cdly[p]);
            hot_rows[0] = '0;
            hot_rows[1] = '1;
            hot_rows[2] = ROW_W'($urandom_range(NUM_ROWS - 1));
            hot_rows[3] = ROW_W'($urandom_range(NUM_ROWS - 1));
            for (int i = 0; i < n_items[p]; i++)
                pending_cycles.insert(pending_cycles.size(), rand_cycle());
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && bank_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
